// ===== rtl/sjbe_pkg.sv =====
// Package for the Shift-JIS backslash escaper.
// Holds lexical mode and pending codes, byte constants and the result struct.
// No dependencies.
package sjbe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 3;

  // lexical mode codes
  localparam logic [CodeW-1:0] MODE_CODE  = 3'd0;
  localparam logic [CodeW-1:0] MODE_STR   = 3'd1;
  localparam logic [CodeW-1:0] MODE_CHR   = 3'd2;
  localparam logic [CodeW-1:0] MODE_BLOCK = 3'd3;
  localparam logic [CodeW-1:0] MODE_LINE  = 3'd4;

  // pending codes
  localparam logic [CodeW-1:0] PEND_NONE  = 3'd0;
  localparam logic [CodeW-1:0] PEND_LEAD  = 3'd1;
  localparam logic [CodeW-1:0] PEND_YEN   = 3'd2;
  localparam logic [CodeW-1:0] PEND_ESC   = 3'd3;
  localparam logic [CodeW-1:0] PEND_STAR  = 3'd4;
  localparam logic [CodeW-1:0] PEND_SLASH = 3'd5;

  // byte values
  localparam logic [ByteW-1:0] CH_NUL     = 8'h00;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
  localparam logic [ByteW-1:0] CH_NL      = 8'h0A;
  localparam logic [ByteW-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [ByteW-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [ByteW-1:0] CH_STAR    = 8'h2A;
  localparam logic [ByteW-1:0] CH_SLASH   = 8'h2F;
  localparam logic [ByteW-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [ByteW-1:0] CH_UNDER   = 8'h5F;
  localparam logic [ByteW-1:0] LEAD1_LO   = 8'h81;
  localparam logic [ByteW-1:0] LEAD1_HI   = 8'h9F;
  localparam logic [ByteW-1:0] LEAD2_LO   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_HI   = 8'hFC;
  localparam logic [ByteW-1:0] TRAIL_LO   = 8'h40;
  localparam logic [ByteW-1:0] TRAIL_HI   = 8'hFC;
  localparam logic [ByteW-1:0] TRAIL_HOLE = 8'h7F;

  // everything one byte produces, plus the next state
  typedef struct packed {
    logic             ins_valid;
    logic [ByteW-1:0] ins_byte;
    logic [ByteW-1:0] out_byte;
    logic             bad_trail;
    logic             nul_fixed;
    logic [CodeW-1:0] mode_d;
    logic [CodeW-1:0] pend_d;
  } sjbe_res_t;

endpackage

// ===== rtl/sjbe_lexer.sv =====
// Combinational lexer step: one source byte against the current mode and
// pending state. Depends on sjbe_pkg.
module sjbe_lexer
  import sjbe_pkg::*;
(
  input  logic [ByteW-1:0] byte_i,
  input  logic             new_file_i,
  input  logic [CodeW-1:0] mode_i,
  input  logic [CodeW-1:0] pend_i,
  output sjbe_res_t        res_o
);

  function automatic logic is_lead(input logic [ByteW-1:0] c);
    return (c >= LEAD1_LO) && ((c <= LEAD1_HI) || ((c >= LEAD2_LO) && (c <= LEAD2_HI)));
  endfunction

  function automatic logic is_trail(input logic [ByteW-1:0] c);
    return (c >= TRAIL_LO) && (c <= TRAIL_HI) && (c != TRAIL_HOLE);
  endfunction

  logic [ByteW-1:0] c;
  logic [CodeW-1:0] mode, pend;
  logic [CodeW-1:0] sp_mode, sp_pend;
  logic [CodeW-1:0] mode_n;

  // new file clears state before the byte; zero becomes a space
  assign mode = new_file_i ? MODE_CODE : mode_i;
  assign pend = new_file_i ? PEND_NONE : pend_i;
  assign c    = (byte_i == CH_NUL) ? CH_SPACE : byte_i;

  // ordinary scan of a byte with nothing pending
  always_comb begin
    sp_mode = mode;
    sp_pend = PEND_NONE;
    if (c == CH_DQUOTE) begin
      if (mode == MODE_CODE) sp_mode = MODE_STR;
      else if (mode == MODE_STR) sp_mode = MODE_CODE;
    end else if (c == CH_SQUOTE) begin
      if (mode == MODE_CODE) sp_mode = MODE_CHR;
      else if (mode == MODE_CHR) sp_mode = MODE_CODE;
    end else if (is_lead(c)) begin
      sp_pend = PEND_LEAD;
    end else if (c == CH_BSLASH) begin
      sp_pend = PEND_ESC;
    end else if ((mode == MODE_BLOCK) && (c == CH_STAR)) begin
      sp_pend = PEND_STAR;
    end else if ((mode == MODE_CODE) && (c == CH_SLASH)) begin
      sp_pend = PEND_SLASH;
    end
  end

  // dispatch on what the previous byte left
  always_comb begin
    res_o           = '0;
    res_o.out_byte  = c;
    res_o.nul_fixed = (byte_i == CH_NUL);
    res_o.ins_byte  = CH_BSLASH;
    mode_n          = mode;
    res_o.pend_d    = PEND_NONE;
    case (pend)
      PEND_LEAD: begin
        res_o.bad_trail = !is_trail(c);
        if (c == CH_BSLASH) res_o.pend_d = PEND_YEN;
      end
      PEND_YEN: begin
        res_o.ins_valid = 1'b1;
        if ((c == CH_NL) && ((mode == MODE_BLOCK) || (mode == MODE_LINE)))
          res_o.ins_byte = CH_UNDER;
        mode_n       = sp_mode;
        res_o.pend_d = sp_pend;
      end
      PEND_ESC: begin
        if (is_lead(c)) res_o.pend_d = PEND_LEAD;
      end
      PEND_STAR: begin
        if (c == CH_SLASH) begin
          mode_n = MODE_CODE;
        end else begin
          mode_n       = sp_mode;
          res_o.pend_d = sp_pend;
        end
      end
      PEND_SLASH: begin
        if (c == CH_STAR) begin
          mode_n = MODE_BLOCK;
        end else if (c == CH_SLASH) begin
          mode_n = MODE_LINE;
        end else begin
          mode_n       = sp_mode;
          res_o.pend_d = sp_pend;
        end
      end
      default: begin
        mode_n       = sp_mode;
        res_o.pend_d = sp_pend;
      end
    endcase
    // newline ends a line comment
    res_o.mode_d = ((c == CH_NL) && (mode_n == MODE_LINE)) ? MODE_CODE : mode_n;
  end

endmodule

// ===== rtl/sjis_backslash_escaper.sv =====
// Top level of the Shift-JIS backslash escaper: input register, lexer step,
// output register holding up to two words. Depends on sjbe_pkg, sjbe_lexer.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid_i/ready_o  | in_byte_i, new_file_i
//  out     | out_valid_o/ready_i | out_byte_o, last_o, bad_trail_o, nul_fixed_o
//
// One input word per cycle when the output does not stall; a word after a 0x5C
// trail byte yields two output words and holds the output register until both have left.
// An accepted word passes the input register, then the output register.
// Reset clears the valid flags, the lexical mode and the pending state.
// A stall on the output backs up through the input register to in_ready_o.
module sjis_backslash_escaper
  import sjbe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             new_file_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_o,
  output logic             bad_trail_o,
  output logic             nul_fixed_o
);

  logic             in_v_q;
  logic [ByteW-1:0] in_byte_q;
  logic             new_file_q;
  logic [CodeW-1:0] mode_q, pend_q;
  logic             out_v_q, ins_q;
  logic [ByteW-1:0] ins_byte_q, byte_q;
  logic             bad_q, nul_q;
  logic             load, step;
  sjbe_res_t        res;

  // output stage can take a new pair when empty or its last word leaves now
  assign load       = !out_v_q || (out_ready_i && !ins_q);
  assign step       = in_v_q && load;
  assign in_ready_o = !in_v_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= in_byte_i;
      new_file_q <= new_file_i;
    end
  end

  sjbe_lexer u_lexer (
    .byte_i     (in_byte_q),
    .new_file_i (new_file_q),
    .mode_i     (mode_q),
    .pend_i     (pend_q),
    .res_o      (res)
  );

  // lexical state advances once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CODE;
      pend_q <= PEND_NONE;
    end else if (step) begin
      mode_q <= res.mode_d;
      pend_q <= res.pend_d;
    end
  end

  // output register: optional inserted word, then the echoed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      ins_q   <= 1'b0;
    end else if (step) begin
      out_v_q <= 1'b1;
      ins_q   <= res.ins_valid;
    end else if (out_v_q && out_ready_i) begin
      if (ins_q) ins_q <= 1'b0;
      else out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      ins_byte_q <= res.ins_byte;
      byte_q     <= res.out_byte;
      bad_q      <= res.bad_trail;
      nul_q      <= res.nul_fixed;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_byte_o  = ins_q ? ins_byte_q : byte_q;
  assign last_o      = !ins_q;
  assign bad_trail_o = !ins_q && bad_q;
  assign nul_fixed_o = !ins_q && nul_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for sjis_backslash_escaper: directed byte table, then
// random C-like text with Shift-JIS characters, checked against a local predictor.
// Depends on sjbe_pkg and the sjis_backslash_escaper RTL.
module tb_top;
  import sjbe_pkg::*;

  localparam int unsigned CycLimit = 300000;
  localparam int unsigned RandBytes = 850;

  // one expected output word
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             bad;
    logic             nul;
  } word_t;

  // one source byte; typed rows carry a hand-written final word
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             nf;
    logic             typed;
    logic [ByteW-1:0] e_data;
    logic             e_bad;
    logic             e_nul;
  } src_byte_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] in_byte_i = '0;
  logic             new_file_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [ByteW-1:0] out_byte_o;
  logic             last_o;
  logic             bad_trail_o;
  logic             nul_fixed_o;

  sjis_backslash_escaper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .new_file_i  (new_file_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .bad_trail_o (bad_trail_o),
    .nul_fixed_o (nul_fixed_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  word_t       due_words[$];
  src_byte_t   src_bytes[$];
  logic        new_file_due = 1'b0;
  int unsigned fails = 0;

  // predictor state
  logic [CodeW-1:0] mode_q = MODE_CODE;
  logic [CodeW-1:0] pend_q = PEND_NONE;

  function automatic bit lead_b(input logic [ByteW-1:0] c);
    return (c >= LEAD1_LO && c <= LEAD1_HI) || (c >= LEAD2_LO && c <= LEAD2_HI);
  endfunction

  function automatic bit trail_b(input logic [ByteW-1:0] c);
    return c >= TRAIL_LO && c <= TRAIL_HI && c != TRAIL_HOLE;
  endfunction

  // plain scan: quotes toggle literals, leads/backslash/comment openers arm pending
  function automatic void lex_scan(input logic [ByteW-1:0] c);
    if (c == CH_DQUOTE) begin
      if (mode_q == MODE_CODE) mode_q = MODE_STR;
      else if (mode_q == MODE_STR) mode_q = MODE_CODE;
    end else if (c == CH_SQUOTE) begin
      if (mode_q == MODE_CODE) mode_q = MODE_CHR;
      else if (mode_q == MODE_CHR) mode_q = MODE_CODE;
    end else if (lead_b(c)) begin
      pend_q = PEND_LEAD;
    end else if (c == CH_BSLASH) begin
      pend_q = PEND_ESC;
    end else if (mode_q == MODE_BLOCK && c == CH_STAR) begin
      pend_q = PEND_STAR;
    end else if (mode_q == MODE_CODE && c == CH_SLASH) begin
      pend_q = PEND_SLASH;
    end
  endfunction

  // advance the escaper state by one byte; returns the number of words (1 or 2)
  function automatic int escape_byte(input logic [ByteW-1:0] b, input logic nf,
                                     output word_t ins, output word_t fin);
    logic [ByteW-1:0] c;
    logic             bad;
    logic             nul;
    logic [CodeW-1:0] was;
    int               n;
    c = b;
    bad = 1'b0;
    nul = 1'b0;
    n = 1;
    ins = '0;
    if (nf) begin
      mode_q = MODE_CODE;
      pend_q = PEND_NONE;
    end
    if (c == CH_NUL) begin
      c = CH_SPACE;
      nul = 1'b1;
    end
    was = pend_q;
    pend_q = PEND_NONE;
    case (was)
      PEND_LEAD: begin
        bad = !trail_b(c);
        if (c == CH_BSLASH) pend_q = PEND_YEN;
      end
      PEND_YEN: begin
        // underscore only for a newline inside a block or line comment
        ins.data = (c == CH_NL && (mode_q == MODE_BLOCK || mode_q == MODE_LINE)) ?
                   CH_UNDER : CH_BSLASH;
        n = 2;
        lex_scan(c);
      end
      PEND_ESC: begin
        if (lead_b(c)) pend_q = PEND_LEAD;
      end
      PEND_STAR: begin
        if (c == CH_SLASH) mode_q = MODE_CODE;
        else lex_scan(c);
      end
      PEND_SLASH: begin
        if (c == CH_STAR) mode_q = MODE_BLOCK;
        else if (c == CH_SLASH) mode_q = MODE_LINE;
        else lex_scan(c);
      end
      default: lex_scan(c);
    endcase
    if (c == CH_NL && mode_q == MODE_LINE) mode_q = MODE_CODE;
    fin.data = c;
    fin.last = 1'b1;
    fin.bad = bad;
    fin.nul = nul;
    return n;
  endfunction

  // mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(2, 1);
    if (r < 97) return $urandom_range(6, 3);
    return $urandom_range(30, 10);
  endfunction

  function automatic logic [ByteW-1:0] rand_lead();
    if ($urandom_range(1) == 0) return ByteW'($urandom_range(LEAD1_HI, LEAD1_LO));
    return ByteW'($urandom_range(LEAD2_HI, LEAD2_LO));
  endfunction

  function automatic void push_src(input logic [ByteW-1:0] b);
    src_bytes.push_back('{b, new_file_due, 1'b0, 8'h00, 1'b0, 1'b0});
    new_file_due = 1'b0;
  endfunction

  // one random text fragment: mostly well-formed tokens, some noise
  function automatic void add_fragment();
    int               r;
    logic [ByteW-1:0] t;
    r = $urandom_range(99);
    if (r < 20) begin
      t = ByteW'($urandom_range(TRAIL_HI, TRAIL_LO));
      if (t == TRAIL_HOLE) t = 8'h80;
      if ($urandom_range(2) == 0) t = CH_BSLASH;
      push_src(rand_lead());
      push_src(t);
    end else if (r < 30) begin
      push_src(CH_NL);
    end else if (r < 38) begin
      push_src(CH_SLASH);
      push_src(CH_STAR);
    end else if (r < 43) begin
      push_src(CH_STAR);
      push_src(CH_SLASH);
    end else if (r < 48) begin
      push_src(CH_SLASH);
      push_src(CH_SLASH);
    end else if (r < 53) begin
      push_src(CH_DQUOTE);
    end else if (r < 57) begin
      push_src(CH_SQUOTE);
    end else if (r < 62) begin
      push_src(CH_BSLASH);
    end else if (r < 65) begin
      push_src(CH_STAR);
    end else if (r < 68) begin
      push_src(CH_SLASH);
    end else if (r < 85) begin
      push_src(ByteW'($urandom_range(8'h7E, 8'h20)));
    end else if (r < 93) begin
      push_src(ByteW'($urandom_range(8'hFF)));
    end else if (r < 96) begin
      push_src(CH_NUL);
    end else if (r < 99) begin
      // lead byte followed by something that is not a trail
      case ($urandom_range(2))
        0:       t = ByteW'($urandom_range(TRAIL_LO - 1));
        1:       t = TRAIL_HOLE;
        default: t = ByteW'($urandom_range(8'hFF, TRAIL_HI + 1));
      endcase
      push_src(rand_lead());
      push_src(t);
    end else begin
      new_file_due = 1'b1;
    end
  endfunction

  // offer one word on the input, wait for accept, then queue its results
  task automatic send_byte(input src_byte_t it, input bit gaps);
    int    gap;
    int    n;
    word_t w_ins;
    word_t w_fin;
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= it.data;
    new_file_i <= it.nf;
    do @(posedge clk_i); while (!in_ready_o);
    n = escape_byte(it.data, it.nf, w_ins, w_fin);
    if (it.typed) begin
      w_fin.data = it.e_data;
      w_fin.bad  = it.e_bad;
      w_fin.nul  = it.e_nul;
    end
    if (n == 2) due_words.push_back(w_ins);
    due_words.push_back(w_fin);
  endtask

  // drop valid and wait until every queued word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_words.size() != 0);
  endtask

  // stimulus
  initial begin
    int n_dir;
    // data, new_file, typed, expected byte, bad_trail, nul_fixed
    src_bytes.push_back('{CH_NUL,    1'b1, 1'b1, CH_SPACE,   1'b0, 1'b1}); // NUL after reset
    src_bytes.push_back('{8'h81,     1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{TRAIL_LO,  1'b0, 1'b1, TRAIL_LO,   1'b0, 1'b0}); // lowest trail
    src_bytes.push_back('{8'h9F,     1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{TRAIL_HOLE, 1'b0, 1'b1, TRAIL_HOLE, 1'b1, 1'b0}); // hole in trails
    src_bytes.push_back('{8'hE0,     1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_NUL,    1'b0, 1'b1, CH_SPACE,   1'b1, 1'b1}); // NUL as trail
    src_bytes.push_back('{8'h81,     1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_NL,     1'b0, 1'b1, CH_NL,      1'b1, 1'b0}); // lead then newline
    src_bytes.push_back('{CH_SLASH,  1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_STAR,   1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // block comment
    src_bytes.push_back('{CH_STAR,   1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_SLASH,  1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // back to code
    src_bytes.push_back('{CH_SLASH,  1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_SLASH,  1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // line comment
    src_bytes.push_back('{CH_DQUOTE, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // quote in comment
    src_bytes.push_back('{8'hFC,     1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_BSLASH, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // 5C trail
    src_bytes.push_back('{CH_NL,     1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // underscore, eol
    src_bytes.push_back('{CH_DQUOTE, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // string
    src_bytes.push_back('{CH_BSLASH, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_DQUOTE, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // escaped quote
    src_bytes.push_back('{CH_BSLASH, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{LEAD2_HI,  1'b0, 1'b0, 8'h00,      1'b0, 1'b0}); // lead after escape
    src_bytes.push_back('{CH_BSLASH, 1'b0, 1'b0, 8'h00,      1'b0, 1'b0});
    src_bytes.push_back('{CH_SQUOTE, 1'b1, 1'b1, CH_SQUOTE,  1'b0, 1'b0}); // new file drops '\'
    src_bytes.push_back('{8'hFF,     1'b0, 1'b1, 8'hFF,      1'b0, 1'b0});
    n_dir = src_bytes.size();
    while (src_bytes.size() < n_dir + RandBytes) add_fragment();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < src_bytes.size(); i++) begin
      if (i == n_dir || i == n_dir + 450) drain();
      // every fourth stretch of 60 words goes without sender gaps
      send_byte(src_bytes[i], (i / 60) % 4 != 2);
    end
    drain();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // output side: compare accepted words, drive out_ready_i with stalls
  word_t       rx_got;
  word_t       rx_due;
  int unsigned rx_seen = 0;
  int unsigned rx_cyc = 0;
  int          rx_stall = 0;
  int          rx_hold = 0;

  function automatic void cmp_field(input string name, input logic [ByteW-1:0] e,
                                    input logic [ByteW-1:0] a);
    if (e !== a) begin
      fails++;
      if (fails <= 40) $error("%s: expected %02h, got %02h", name, e, a);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rx_cyc++;
      if (out_valid_o && out_ready_i) begin
        rx_got = {out_byte_o, last_o, bad_trail_o, nul_fixed_o};
        if (due_words.size() == 0) begin
          fails++;
          if (fails <= 40) $error("unexpected output word %02h", out_byte_o);
        end else begin
          rx_due = due_words.pop_front();
          cmp_field("out_byte", rx_due.data, rx_got.data);
          cmp_field("last", ByteW'(rx_due.last), ByteW'(rx_got.last));
          cmp_field("bad_trail", ByteW'(rx_due.bad), ByteW'(rx_got.bad));
          cmp_field("nul_fixed", ByteW'(rx_due.nul), ByteW'(rx_got.nul));
        end
        rx_seen++;
        // long hold-off so the block backs up into its input
        if (rx_seen % 700 == 300) rx_hold = 250;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else if ((rx_cyc / 500) % 4 == 3) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_stall = pick_gap();
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // watchdog
  int unsigned wd_cyc = 0;
  always @(posedge clk_i) begin
    wd_cyc++;
    if (wd_cyc >= CycLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
